/* rtl/smrg_pkg.sv */
package smrg_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	localparam logic [1:0] CMD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_MERGE  = 2'd2;

	localparam logic [1:0] STAT_RECORD = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_EMPTY  = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] key;
		logic [15:0]        tag;
	} item_t;

	typedef struct packed {
		logic signed [31:0] key_res;
		logic [15:0]        tag_res;
		logic               from_second;
		logic [1:0]         status;
		logic               last;
	} result_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [15:0]        tag;
	} rec_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} buf_ctl_t;

	typedef struct packed {
		rec_t head;
		logic full;
		logic avail;
		logic one_left;
	} buf_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

endpackage

/* rtl/smrg_buf.sv */
module smrg_buf
	import smrg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  buf_ctl_t  ctl,
	input  rec_t      wr_rec,
	output buf_stat_t stat
);

	rec_t             mem [LIST_DEPTH];
	rec_t             head_rec_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] head_d;

	always_comb begin
		head_d = head_q;
		if (ctl.clr) begin
			head_d = '0;
		end else if (ctl.pop) begin
			head_d = head_q + CNT_W'(1);
		end
	end

	// The head word is registered from the next head index; a push into the slot
	// that becomes the head is forwarded straight from the write data.
	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clr) begin
			mem[count_q[IDX_W-1:0]] <= wr_rec;
		end
		if (ctl.push && !ctl.clr && (count_q == head_d)) begin
			head_rec_q <= wr_rec;
		end else begin
			head_rec_q <= mem[head_d[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else if (ctl.clr) begin
			count_q <= '0;
			head_q  <= '0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + CNT_W'(1);
			end
			head_q <= head_d;
		end
	end

	always_comb begin
		stat.head     = head_rec_q;
		stat.full     = (count_q == CNT_W'(LIST_DEPTH));
		stat.avail    = (head_q < count_q);
		stat.one_left = ((head_q + CNT_W'(1)) == count_q);
	end

endmodule

/* rtl/smrg_ctrl.sv */
module smrg_ctrl
	import smrg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  item_t     item,
	input  buf_stat_t stat_a,
	input  buf_stat_t stat_b,
	output logic      busy,
	output buf_ctl_t  ctl_a,
	output buf_ctl_t  ctl_b,
	output result_t   result,
	output logic      res_valid
);

	state_t  state_q, state_d;
	result_t res_q, res_d;
	logic    res_valid_q, res_valid_d;
	logic    accept;
	logic    take_first;
	logic    merge_last;
	logic    nothing_held;

	assign accept       = start && (state_q == ST_IDLE);
	assign nothing_held = !stat_a.avail && !stat_b.avail;

	// The single key comparator; ties go to the first list.
	assign take_first = stat_a.avail &&
		(!stat_b.avail || ($signed(stat_a.head.key) <= $signed(stat_b.head.key)));
	assign merge_last = take_first ? (stat_a.one_left && !stat_b.avail)
	                               : (stat_b.one_left && !stat_a.avail);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.command == CMD_MERGE && !nothing_held) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (merge_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl_a       = '0;
		ctl_b       = '0;
		res_d       = '0;
		res_valid_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.command)
						CMD_FIRST: begin
							if (stat_a.full) begin
								res_d.status = STAT_FULL;
								res_d.last   = 1'b1;
								res_valid_d  = 1'b1;
							end else begin
								ctl_a.push = 1'b1;
							end
						end
						CMD_SECOND: begin
							if (stat_b.full) begin
								res_d.status      = STAT_FULL;
								res_d.from_second = 1'b1;
								res_d.last        = 1'b1;
								res_valid_d       = 1'b1;
							end else begin
								ctl_b.push = 1'b1;
							end
						end
						CMD_MERGE: begin
							if (nothing_held) begin
								res_d.status = STAT_EMPTY;
								res_d.last   = 1'b1;
								res_valid_d  = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_MERGE: begin
				ctl_a.pop         = take_first;
				ctl_b.pop         = !take_first;
				ctl_a.clr         = merge_last;
				ctl_b.clr         = merge_last;
				res_d.key_res     = take_first ? stat_a.head.key : stat_b.head.key;
				res_d.tag_res     = take_first ? stat_a.head.tag : stat_b.head.tag;
				res_d.from_second = !take_first;
				res_d.status      = STAT_RECORD;
				res_d.last        = merge_last;
				res_valid_d       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign result    = res_q;
	assign res_valid = res_valid_q;

endmodule

/* rtl/sorted_two_way_merge_unit.sv */
// Two buffers of up to LIST_DEPTH (key, tag) words each, merged into one
// ascending run on a merge command; the user must load each in ascending key
// order, which the block itself does not enforce. An append leaves busy low,
// so a new command may follow at once; a rejected append shows its status
// word in the cycle after the command. A merge holds busy high until its last
// word is picked, as a single signed key comparator picks one head word each
// cycle; each word appears on result in the cycle after it is picked, for
// exactly one cycle under res_valid, with last set on the final one. A merge with
// nothing stored returns one status word in the next cycle. The receiver cannot
// stall the block, so every word must be captured in the cycle it is strobed.
module sorted_two_way_merge_unit
	import smrg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output result_t result,
	output logic    res_valid
);

	buf_ctl_t  ctl_a, ctl_b;
	buf_stat_t stat_a, stat_b;
	rec_t      wr_rec;

	assign wr_rec.key = item.key;
	assign wr_rec.tag = item.tag;

	smrg_buf u_buf_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_a),
		.wr_rec (wr_rec),
		.stat   (stat_a)
	);

	smrg_buf u_buf_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_b),
		.wr_rec (wr_rec),
		.stat   (stat_b)
	);

	smrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.stat_a    (stat_a),
		.stat_b    (stat_b),
		.busy      (busy),
		.ctl_a     (ctl_a),
		.ctl_b     (ctl_b),
		.result    (result),
		.res_valid (res_valid)
	);

endmodule

/* tb/sorted_two_way_merge_unit_tb.sv */
`timescale 1ns / 100ps

module sorted_two_way_merge_unit_tb;
	import smrg_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
	localparam int TARGET_COMMANDS = 220;

	typedef logic signed [31:0] key_q_t[$];

	// Tracks both buffers and the words each accepted command must produce.
	class merge_tracker;
		rec_t        first_list[$];
		rec_t        second_list[$];
		result_t     pending_words[$];
		int unsigned error_count;
		int unsigned words_checked;
		int unsigned merges;
		int unsigned full_rejects;
		int unsigned empty_merges;

		function void note_command(input item_t cmd);
			rec_t    rec;
			result_t word;
			int      i;
			int      j;
			int      total;
			bit      take_first;
			rec.key = cmd.key;
			rec.tag = cmd.tag;
			word = '0;
			case (cmd.command)
			CMD_FIRST, CMD_SECOND: begin
				if ((cmd.command == CMD_FIRST ? first_list.size() : second_list.size())
						>= LIST_DEPTH) begin
					word.from_second = (cmd.command == CMD_SECOND);
					word.status = STAT_FULL;
					word.last = 1'b1;
					pending_words.push_back(word);
					full_rejects++;
				end else if (cmd.command == CMD_FIRST) begin
					first_list.push_back(rec);
				end else begin
					second_list.push_back(rec);
				end
			end
			CMD_MERGE: begin
				merges++;
				total = first_list.size() + second_list.size();
				if (total == 0) begin
					word.status = STAT_EMPTY;
					word.last = 1'b1;
					pending_words.push_back(word);
					empty_merges++;
				end
				i = 0;
				j = 0;
				while (i + j < total) begin
					// Ties go to the first list, which keeps the merge stable.
					take_first = (i < first_list.size()) && (j >= second_list.size() ||
						$signed(first_list[i].key) <= $signed(second_list[j].key));
					rec = take_first ? first_list[i] : second_list[j];
					if (take_first)
						i++;
					else
						j++;
					word.key_res = rec.key;
					word.tag_res = rec.tag;
					word.from_second = !take_first;
					word.status = STAT_RECORD;
					word.last = (i + j == total);
					pending_words.push_back(word);
				end
				first_list.delete();
				second_list.delete();
			end
			default: begin
			end
			endcase
		endfunction

		function void check_word(input result_t got);
			result_t want;
			if (pending_words.size() == 0) begin
				$error("unexpected result word: key_res %0d tag_res %0h status %0d",
					got.key_res, got.tag_res, got.status);
				error_count++;
				return;
			end
			want = pending_words.pop_front();
			words_checked++;
			if (got.key_res !== want.key_res) begin
				$error("key_res: expected %0d, got %0d", want.key_res, got.key_res);
				error_count++;
			end
			if (got.tag_res !== want.tag_res) begin
				$error("tag_res: expected %0h, got %0h", want.tag_res, got.tag_res);
				error_count++;
			end
			if (got.from_second !== want.from_second) begin
				$error("from_second: expected %0b, got %0b", want.from_second, got.from_second);
				error_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				error_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				error_count++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	result_t result;
	logic    res_valid;

	merge_tracker tracker;
	bit           idle_on;
	int           issued;
	int           drain_cycles;

	sorted_two_way_merge_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.result   (result),
		.res_valid(res_valid)
	);

	always #5 clk = ~clk;

	// Words of earlier commands are checked before a command taken at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid)
				tracker.check_word(result);
			if (start && !busy)
				tracker.note_command(item);
		end
	end

	task automatic issue(input logic [1:0] cmd, input logic signed [31:0] key,
			input logic [15:0] tag);
		item_t word_in;
		word_in.command = cmd;
		word_in.key = key;
		word_in.tag = tag;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 34) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= word_in;
		do
			@(posedge clk);
		while (busy);
		if (cmd != CMD_UNUSED)
			issued++;
	endtask

	function automatic key_q_t make_keys(input int n, input bit narrow, input bit ordered);
		key_q_t             keys;
		logic signed [31:0] k;
		int                 p;
		for (int i = 0; i < n; i++) begin
			if (narrow)
				k = $urandom_range(8) - 4;
			else begin
				case ($urandom_range(15))
				0: k = KEY_MIN;
				1: k = KEY_MAX;
				default: k = $urandom;
				endcase
			end
			p = keys.size();
			while (ordered && p > 0 && keys[p - 1] > k)
				p--;
			keys.insert(p, k);
		end
		return keys;
	endfunction

	function automatic int pick_size();
		int roll = $urandom_range(9);
		if (roll < 7)
			return $urandom_range(6);
		if (roll < 9)
			return $urandom_range(LIST_DEPTH, 7);
		return $urandom_range(LIST_DEPTH + 2, LIST_DEPTH);
	endfunction

	// Interleaves appends to both lists randomly, with stray unused commands; may then merge.
	task automatic run_batch(input int n_first, input int n_second, input bit narrow,
			input bit ordered, input bit do_merge);
		key_q_t keys_a;
		key_q_t keys_b;
		int     ia;
		int     ib;
		bit     pick_first;
		keys_a = make_keys(n_first, narrow, ordered);
		keys_b = make_keys(n_second, narrow, ordered);
		ia = 0;
		ib = 0;
		while (ia < n_first || ib < n_second) begin
			if ($urandom_range(19) == 0)
				issue(CMD_UNUSED, $urandom, 16'($urandom));
			pick_first = (ib >= n_second) || (ia < n_first && $urandom_range(1) == 1);
			if (pick_first) begin
				issue(CMD_FIRST, keys_a[ia], 16'($urandom));
				ia++;
			end else begin
				issue(CMD_SECOND, keys_b[ib], 16'($urandom));
				ib++;
			end
		end
		if (do_merge)
			issue(CMD_MERGE, $urandom, 16'($urandom));
	endtask

	initial begin
		tracker = new();
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		issued = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		issue(CMD_MERGE, KEY_MAX, 16'hffff);
		issue(CMD_UNUSED, KEY_MAX, 16'hffff);
		issue(CMD_FIRST, KEY_MIN, 16'h0000);
		issue(CMD_SECOND, KEY_MAX, 16'hffff);
		issue(CMD_FIRST, KEY_MAX, 16'h0001);
		issue(CMD_MERGE, KEY_MIN, 16'h0000);
		issue(CMD_SECOND, -1, 16'h00a5);
		issue(CMD_SECOND, 0, 16'h5a00);
		issue(CMD_MERGE, 0, 16'h0000);
		// Equal keys on both sides: the first list must drain its ties first.
		issue(CMD_FIRST, 7, 16'h000a);
		issue(CMD_SECOND, 7, 16'h000b);
		issue(CMD_SECOND, 7, 16'h000c);
		issue(CMD_FIRST, 7, 16'h000d);
		issue(CMD_MERGE, 0, 16'h0000);
		issue(CMD_FIRST, 0, 16'h1234);
		issue(CMD_MERGE, 0, 16'h0000);

		run_batch(LIST_DEPTH + 1, LIST_DEPTH + 1, 1'b0, 1'b1, 1'b1);
		while (issued < TARGET_COMMANDS) begin
			idle_on = !(issued >= 100 && issued < 170);
			run_batch(pick_size(), pick_size(), $urandom_range(2) == 0,
				$urandom_range(9) != 0, $urandom_range(7) != 0);
		end
		idle_on = 1'b1;
		issue(CMD_MERGE, 0, 16'h0000);
		@(negedge clk);
		start <= 1'b0;

		for (drain_cycles = 0; drain_cycles < 1000 && tracker.pending_words.size() != 0;
				drain_cycles++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.pending_words.size() != 0) begin
			$error("%0d result words never arrived", tracker.pending_words.size());
			tracker.error_count++;
		end

		$display("Ran %0d commands including %0d merges (%0d with both lists empty).",
			issued, tracker.merges, tracker.empty_merges);
		$display("Checked %0d result words, %0d of them rejected appends to a full list.",
			tracker.words_checked, tracker.full_rejects);
		if (tracker.error_count == 0)
			$display("sorted_two_way_merge_unit_tb: clean");
		else
			$display("sorted_two_way_merge_unit_tb: errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("sorted_two_way_merge_unit_tb: errors");
		$finish;
	end

endmodule

/* sim.f */
rtl/smrg_pkg.sv
rtl/smrg_buf.sv
rtl/smrg_ctrl.sv
rtl/sorted_two_way_merge_unit.sv
tb/sorted_two_way_merge_unit_tb.sv
